FILE: design/base64_stream_decoder_macros.svh
// assertion macros shared by the base64 stream decoder modules
// expects signals aclk and aresetn in the scope of each use
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define B64SD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define B64SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/b64sd_pkg.sv
// shared types, constants and functions of the base64 stream decoder
// no dependencies
package b64sd_pkg;

    // character and status codes
    localparam logic [7:0] PAD_CHAR       = 8'h3D;
    localparam logic       STATUS_OK      = 1'b0;
    localparam logic       STATUS_LEN_ERR = 1'b1;

    // positions inside a four character group
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // byte counts of one group
    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    // command queue geometry, depth is a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one command from the front end to the byte emitter
    typedef struct packed {
        logic [23:0] value;
        logic [1:0]  nbytes;
        logic        last;
        logic        err;
    } b64sd_cmd_t;

    // rfc 4648 standard alphabet, anything else maps to zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        case (c) inside
            [8'h41:8'h5A]: d = c - 8'h41;
            [8'h61:8'h7A]: d = c - 8'd71;
            [8'h30:8'h39]: d = c + 8'd4;
            8'h2B:         d = 8'd62;
            8'h2F:         d = 8'd63;
            default:       d = 8'h00;
        endcase
        return d[5:0];
    endfunction

    // byte of a 24-bit group, most significant first
    function automatic logic [7:0] byte_of(input logic [23:0] value, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            2'd0:    b = value[23:16];
            2'd1:    b = value[15:8];
            2'd2:    b = value[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: design/base64_stream_decoder.sv
// Base64 stream decoder (rfc 4648 standard alphabet).
// Input channel s_*: one character per transaction, s_is_last marks the final one.
// Output channel m_*: one decoded byte per transaction; m_last_byte marks the final
// result of a decode, m_status = 1 flags a length error (text ends inside a group),
// sent as one zero byte after any bytes of earlier groups.
// Characters outside the alphabet, and '=' outside the final group, decode as zero.
// Throughput: one character per cycle while the queue has room; each group of four
// characters yields up to three bytes, emitted one per cycle while m_ready is high.
// A completed group enters the queue when its fourth character is accepted; its
// first byte is then loaded from the queue head into the output register, and the
// other bytes follow on consecutive cycles when m_ready is high.
// A four-entry group queue separates the character side from the byte side, so
// the input keeps flowing while a byte waits at the output; when the receiver
// stalls long enough to fill the queue, s_ready drops until an entry drains.
// Reset (aresetn low, synchronous) empties the queue, drops m_valid and starts a
// fresh group; the group state also returns to its start after each final character.
// Depends on b64sd_pkg, b64sd_front, b64sd_fifo, b64sd_back.
module base64_stream_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_char_code,
    input  logic       s_is_last,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_data_byte,
    output logic       m_last_byte,
    output logic       m_status,
    output logic       m_valid,
    input  logic       m_ready
);
    import b64sd_pkg::*;

    logic       push_valid;
    b64sd_cmd_t push_cmd;
    logic       q_full;
    logic       q_empty;
    b64sd_cmd_t head_cmd;
    logic       pop;

    // character intake and group assembly
    b64sd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_char_code (s_char_code),
        .s_is_last   (s_is_last),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd),
        .q_full      (q_full)
    );

    // group command queue
    b64sd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .empty      (q_empty),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // byte emission
    b64sd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .empty       (q_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .m_data_byte (m_data_byte),
        .m_last_byte (m_last_byte),
        .m_status    (m_status),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

endmodule

FILE: design/b64sd_front.sv
// front end: accepts characters, decodes sextets, builds group commands
// depends on b64sd_pkg
module b64sd_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_char_code,
    input  logic                   s_is_last,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   push_valid,
    output b64sd_pkg::b64sd_cmd_t  push_cmd,
    input  logic                   q_full
);
    import b64sd_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        pad3_reg, pad3_next;
    logic        accept;
    logic [5:0]  sextet;
    logic        is_pad;

    // take a character whenever the queue has room
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign sextet  = sextet_of(s_char_code);
    assign is_pad  = (s_char_code == PAD_CHAR);

    // group assembly and command build
    always_comb begin
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        pad3_next       = pad3_reg;
        push_valid      = 1'b0;
        push_cmd.value  = {acc_reg, sextet};
        push_cmd.nbytes = NBYTES_THREE;
        push_cmd.last   = s_is_last;
        push_cmd.err    = STATUS_OK;
        if (accept) begin
            if (pos_reg == POS_FOURTH) begin
                // group complete, padding only counts in the final group
                push_valid = 1'b1;
                if (s_is_last && is_pad) begin
                    push_cmd.nbytes = pad3_reg ? NBYTES_ONE : NBYTES_TWO;
                end
                pos_next  = 2'd0;
                acc_next  = 18'd0;
                pad3_next = 1'b0;
            end else begin
                if (pos_reg == POS_THIRD) begin
                    pad3_next = is_pad;
                end
                acc_next = {acc_reg[11:0], sextet};
                pos_next = pos_reg + 2'd1;
                if (s_is_last) begin
                    // text ends inside a group
                    push_valid      = 1'b1;
                    push_cmd.value  = 24'd0;
                    push_cmd.nbytes = NBYTES_ONE;
                    push_cmd.err    = STATUS_LEN_ERR;
                    pos_next        = 2'd0;
                    acc_next        = 18'd0;
                    pad3_next       = 1'b0;
                end
            end
        end
    end

    // group state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 2'd0;
            acc_reg  <= 18'd0;
            pad3_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            pad3_reg <= pad3_next;
        end
    end

endmodule

FILE: design/b64sd_fifo.sv
// short command queue between front end and byte emitter
// depends on b64sd_pkg and base64_stream_decoder_macros.svh
`include "base64_stream_decoder_macros.svh"

module b64sd_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    input  b64sd_pkg::b64sd_cmd_t  push_cmd,
    output logic                   full,
    output logic                   empty,
    output b64sd_pkg::b64sd_cmd_t  head_cmd,
    input  logic                   pop
);
    import b64sd_pkg::*;

    b64sd_cmd_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push_valid && !full;
    assign do_pop   = pop && !empty;

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `B64SD_ASSERT_NOW(a_no_push_full, push_valid, !full, "command pushed into full queue")
    `B64SD_ASSERT_NOW(a_no_pop_empty, pop, !empty, "command popped from empty queue")
    `B64SD_ASSERT_NOW(a_count_range, 1'b1, count_reg <= QCNT_W'(QDEPTH), "queue count overflow")

endmodule

FILE: design/b64sd_back.sv
// byte emitter: walks the head command one byte per cycle, while the output register is free, into the output register
// depends on b64sd_pkg and base64_stream_decoder_macros.svh
`include "base64_stream_decoder_macros.svh"

module b64sd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   empty,
    input  b64sd_pkg::b64sd_cmd_t  head_cmd,
    output logic                   pop,
    output logic [7:0]             m_data_byte,
    output logic                   m_last_byte,
    output logic                   m_status,
    output logic                   m_valid,
    input  logic                   m_ready
);
    import b64sd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       status_reg;
    logic       load;
    logic       final_byte;

    // output register is free when empty or being taken
    assign load       = !empty && (!valid_reg || m_ready);
    assign final_byte = (idx_reg == head_cmd.nbytes - 2'd1);
    assign pop        = load && final_byte;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = final_byte ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg   <= byte_of(head_cmd.value, idx_reg);
            last_reg   <= head_cmd.last && final_byte;
            status_reg <= head_cmd.err;
        end
    end

    assign m_valid     = valid_reg;
    assign m_data_byte = data_reg;
    assign m_last_byte = last_reg;
    assign m_status    = status_reg;

    `B64SD_ASSERT_NOW(a_err_is_last, valid_reg && status_reg, last_reg && (data_reg == 8'h00),
        "length error result must be final and zero")
    `B64SD_ASSERT_NOW(a_head_nbytes, !empty, head_cmd.nbytes != 2'd0, "command with no bytes")
    `B64SD_ASSERT_NEXT(a_idx_restart, pop, idx_reg == 2'd0, "byte index not restarted after pop")

endmodule
